// ===== rtl/sgc_pkg.sv =====
// ----------------------------------------------------------------------------
// sgc_pkg
// Shared types, constants and the divider step for the shading gain block.
// ----------------------------------------------------------------------------
package sgc_pkg;

    localparam int LVL_W      = 8;                 // white, dark, target, gain
    localparam int GAIN_SHIFT = 6;                 // one unit of gain = 64
    localparam int NUM_W      = LVL_W + GAIN_SHIFT; // numerator / quotient bits
    localparam int CFG_IDX_W  = 8;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [NUM_W-1:0] GAIN_ONE = NUM_W'(1 << GAIN_SHIFT);
    localparam logic [NUM_W-1:0] GAIN_MAX = NUM_W'((1 << LVL_W) - 1);

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WHITE_LEVEL = CFG_IDX_W'(1);

    localparam logic [LVL_W-1:0] TARGET_RESET    = LVL_W'(240);
    localparam logic [LVL_W-1:0] MIN_WHITE_RESET = LVL_W'(16);

    typedef struct packed {
        logic [LVL_W-1:0] white_level;
        logic [LVL_W-1:0] dark_level;
        logic             end_of_line;
    } in_word_t;

    typedef struct packed {
        logic [LVL_W-1:0] gain;
        logic [LVL_W-1:0] dark_out;
        logic             rejected;
        logic             saturated;
        logic             end_of_line_out;
    } out_word_t;

    // classified pixel, front to back
    typedef struct packed {
        logic             rej;
        logic [NUM_W-1:0] numer;
        logic [LVL_W-1:0] divisor;
        logic [LVL_W-1:0] dark;
        logic             eol;
    } task_t;

    // one divider stage
    typedef struct packed {
        logic [LVL_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        logic [LVL_W-1:0] divisor;
        logic [LVL_W-1:0] dark;
        logic             rej;
        logic             eol;
    } div_t;

    // one restoring division step: one quotient bit
    function automatic div_t div_step(input div_t s);
        div_t         r;
        logic [LVL_W:0] trial;
        trial = {s.rem, s.num[NUM_W-1]};
        r     = s;
        r.num = {s.num[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, s.divisor}) begin
            r.rem = LVL_W'(trial - {1'b0, s.divisor});
            r.quo = {s.quo[NUM_W-2:0], 1'b1};
        end else begin
            r.rem = trial[LVL_W-1:0];
            r.quo = {s.quo[NUM_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/sgc_front.sv =====
// ----------------------------------------------------------------------------
// sgc_front
// Accepts pixels, applies the reject test and forms numerator and divisor.
// ----------------------------------------------------------------------------
module sgc_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [sgc_pkg::LVL_W-1:0] target_level,
    input  logic [sgc_pkg::LVL_W-1:0] min_white_level,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  sgc_pkg::in_word_t       s_data,
    output logic                    t_valid,
    input  logic                    t_ready,
    output sgc_pkg::task_t          t_data
);
    import sgc_pkg::*;

    logic  t_valid_reg;
    task_t t_data_reg;
    task_t t_data_next;

    assign s_ready = !t_valid_reg || t_ready;
    assign t_valid = t_valid_reg;
    assign t_data  = t_data_reg;

    always_comb begin
        t_data_next.rej     = (s_data.white_level <= min_white_level) ||
                              (s_data.white_level <= s_data.dark_level);
        t_data_next.numer   = NUM_W'(target_level) << GAIN_SHIFT;
        t_data_next.divisor = s_data.white_level - s_data.dark_level;
        t_data_next.dark    = s_data.dark_level;
        t_data_next.eol     = s_data.end_of_line;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_valid_reg <= 1'b0;
        end else if (s_ready) begin
            t_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            t_data_reg <= t_data_next;
        end
    end

endmodule

// ===== rtl/sgc_queue.sv =====
// ----------------------------------------------------------------------------
// sgc_queue
// Short FIFO between front and divider back end.
// ----------------------------------------------------------------------------
module sgc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  sgc_pkg::task_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output sgc_pkg::task_t out_data
);
    import sgc_pkg::*;

    task_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/sgc_back.sv =====
// ----------------------------------------------------------------------------
// sgc_back
// Pipelined restoring divider, one quotient bit per stage, then gain clamp
// and output register.
// ----------------------------------------------------------------------------
module sgc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sgc_pkg::task_t     in_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sgc_pkg::out_word_t m_data
);
    import sgc_pkg::*;

    div_t      stage_reg     [NUM_W];
    logic      stage_vld_reg [NUM_W];
    logic      m_valid_reg;
    out_word_t m_data_reg;
    out_word_t m_data_next;
    div_t      head;
    logic      advance;
    logic [NUM_W-1:0] quo;
    logic [NUM_W-1:0] excess;

    // whole pipe moves together when the output slot frees up
    assign advance  = !m_valid_reg || m_ready;
    assign in_ready = advance;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        head.rem     = '0;
        head.num     = in_data.numer;
        head.quo     = '0;
        head.divisor = in_data.divisor;
        head.dark    = in_data.dark;
        head.rej     = in_data.rej;
        head.eol     = in_data.eol;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_vld_reg[0] <= 1'b0;
        end else if (advance) begin
            stage_vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            stage_reg[0] <= div_step(head);
        end
    end

    for (genvar k = 1; k < NUM_W; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stage_vld_reg[k] <= 1'b0;
            end else if (advance) begin
                stage_vld_reg[k] <= stage_vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                stage_reg[k] <= div_step(stage_reg[k-1]);
            end
        end
    end

    // q - 64, clamped at zero, saturated at 255
    assign quo    = stage_reg[NUM_W-1].quo;
    assign excess = quo - GAIN_ONE;

    always_comb begin
        m_data_next.gain            = '0;
        m_data_next.dark_out        = '0;
        m_data_next.rejected        = stage_reg[NUM_W-1].rej;
        m_data_next.saturated       = 1'b0;
        m_data_next.end_of_line_out = stage_reg[NUM_W-1].eol;
        if (!stage_reg[NUM_W-1].rej) begin
            m_data_next.dark_out = stage_reg[NUM_W-1].dark;
            if (quo > GAIN_ONE) begin
                if (excess > GAIN_MAX) begin
                    m_data_next.gain      = GAIN_MAX[LVL_W-1:0];
                    m_data_next.saturated = 1'b1;
                end else begin
                    m_data_next.gain = excess[LVL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= stage_vld_reg[NUM_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    a_rej_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.rejected |->
            m_data_reg.gain == '0 && m_data_reg.dark_out == '0 &&
            !m_data_reg.saturated)
        else $error("rejected pixel carries nonzero result");

    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.saturated |->
            m_data_reg.gain == GAIN_MAX[LVL_W-1:0] && !m_data_reg.rejected)
        else $error("saturated flag without full-scale gain");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(stage_vld_reg[NUM_W-1]) && $stable(stage_vld_reg[0]))
        else $error("divider pipe moved while output stalled");

endmodule

// ===== rtl/shading_gain_calc_core.sv =====
// ----------------------------------------------------------------------------
// shading_gain_calc_core
// Flat-field shading correction gain: one pixel word in, one gain word out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one word per pixel (white level, dark level, end of line).
//   m_* channel: one result word per pixel, in input order (gain code with
//     64 per unit above one, dark passthrough, rejected/saturated flags).
//   cfg_* channel: register writes, always ready. Index 0 = target_level,
//     index 1 = min_white_level; other indexes are dropped. Write only when
//     the block is drained.
// Timing:
//   Sustained rate is one pixel per cycle while the result side does not
//   stall. From input acceptance to m_valid a pixel passes the front
//   register (loaded on the accepting edge itself), the queue slot, the
//   14-stage divider pipe (one quotient bit per stage) and the output
//   register.
// Reset (aresetn low, synchronous): all words in flight are dropped, the
//   registers return to target 240 / min white 16.
// Stall: while a result waits on m_ready low the divider pipe holds; the
//   2-word queue and the front register keep taking pixels until they fill,
//   then s_ready drops.
// ----------------------------------------------------------------------------
module shading_gain_calc_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sgc_pkg::in_word_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sgc_pkg::out_word_t              m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sgc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sgc_pkg::LVL_W-1:0]       cfg_data
);
    import sgc_pkg::*;

    // configuration registers
    logic [LVL_W-1:0] target_level_reg;
    logic [LVL_W-1:0] min_white_level_reg;

    // front -> queue -> back
    logic  f_valid;
    logic  f_ready;
    task_t f_data;
    logic  q_valid;
    logic  q_ready;
    task_t q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_level_reg    <= TARGET_RESET;
            min_white_level_reg <= MIN_WHITE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_TARGET_LEVEL) begin
                target_level_reg <= cfg_data;
            end else if (cfg_index == REG_MIN_WHITE_LEVEL) begin
                min_white_level_reg <= cfg_data;
            end
        end
    end

    // reject test and operand setup
    sgc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .target_level    (target_level_reg),
        .min_white_level (min_white_level_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .t_valid         (f_valid),
        .t_ready         (f_ready),
        .t_data          (f_data)
    );

    // decouples front from divider stalls
    sgc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // divider pipe, clamp, output register
    sgc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_data  (q_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for shading_gain_calc_core. A plan of pixel words,
// register writes, drain points and idle phases is built up front; a clocked
// driver plays it out on the s_ and cfg_ channels, and a clocked monitor
// predicts each accepted pixel's gain word and checks the m_ channel in order.
// ----------------------------------------------------------------------------
module testbench;

    import sgc_pkg::*;

    localparam int UNITY_GAIN       = 64;   // gain code for a factor of one
    localparam int GAIN_CEIL        = 255;
    localparam int TARGET_AT_RESET  = 240;
    localparam int MIN_WHITE_AT_RST = 16;
    localparam int FIRST_UNUSED_REG = 2;    // indexes from here up are dropped
    localparam int WATCHDOG_LIMIT   = 2000; // cycles without any handshake
    localparam int SETTLE_CYCLES    = 40;   // > pipe latency, catches strays
    localparam int MAX_PRINTED      = 100;
    localparam int BLOCK_PIXELS     = 154;

    typedef enum logic [1:0] {
        STEP_PIXEL,
        STEP_CFG,
        STEP_DRAIN,
        STEP_PHASE
    } step_kind_t;

    typedef struct {
        step_kind_t              kind;
        in_word_t                px;
        logic [CFG_IDX_W-1:0]    idx;
        logic [LVL_W-1:0]        val;
        int                      src_idle;
        int                      snk_stall;
    } plan_step_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_word_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_word_t              m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [LVL_W-1:0]       cfg_data;

    plan_step_t     pixel_plan[$];
    out_word_t      pending_gains[$];
    int             src_idle_pct;
    int             snk_stall_pct;
    int             err_count;
    int             quiet_cycles;
    int             result_count;
    int             plan_min_white;     // min white as the plan will have set it
    logic [LVL_W-1:0] cur_target;       // predictor's copy of the registers
    logic [LVL_W-1:0] cur_min_white;

    shading_gain_calc_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Gain prediction
    // ------------------------------------------------------------------------
    function automatic out_word_t shading_gain(input in_word_t px);
        out_word_t   r;
        int unsigned diff;
        int unsigned quo;
        r = '0;
        r.end_of_line_out = px.end_of_line;
        if (px.white_level <= cur_min_white || px.white_level <= px.dark_level) begin
            r.rejected = 1'b1;
        end else begin
            diff = px.white_level - px.dark_level;
            quo  = (UNITY_GAIN * cur_target) / diff;
            r.dark_out = px.dark_level;
            // quotient at or below one unit leaves the gain at zero
            if (quo > UNITY_GAIN) begin
                if (quo - UNITY_GAIN > GAIN_CEIL) begin
                    r.gain      = LVL_W'(GAIN_CEIL);
                    r.saturated = 1'b1;
                end else begin
                    r.gain = LVL_W'(quo - UNITY_GAIN);
                end
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        if (err_count < MAX_PRINTED) begin
            $display("MISMATCH @%0t result %0d: %s", $realtime, result_count, msg);
        end
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Plan building
    // ------------------------------------------------------------------------
    task automatic plan_pixel(input int white, input int dark, input bit eol);
        plan_step_t st;
        st = '{kind: STEP_PIXEL, px: '0, idx: '0, val: '0, src_idle: 0, snk_stall: 0};
        st.px.white_level = LVL_W'(white);
        st.px.dark_level  = LVL_W'(dark);
        st.px.end_of_line = eol;
        pixel_plan.push_back(st);
    endtask

    task automatic plan_drain();
        plan_step_t st;
        st = '{kind: STEP_DRAIN, px: '0, idx: '0, val: '0, src_idle: 0, snk_stall: 0};
        pixel_plan.push_back(st);
    endtask

    // drain, then both registers, then a write to an unused index
    task automatic plan_settings(input int target, input int min_white);
        plan_step_t st;
        plan_drain();
        st = '{kind: STEP_CFG, px: '0, idx: REG_TARGET_LEVEL, val: LVL_W'(target),
               src_idle: 0, snk_stall: 0};
        pixel_plan.push_back(st);
        st.idx = REG_MIN_WHITE_LEVEL;
        st.val = LVL_W'(min_white);
        pixel_plan.push_back(st);
        st.idx = CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, FIRST_UNUSED_REG));
        st.val = LVL_W'($urandom);
        pixel_plan.push_back(st);
        plan_min_white = min_white;
    endtask

    task automatic plan_phase(input int src_idle, input int snk_stall);
        plan_step_t st;
        st = '{kind: STEP_PHASE, px: '0, idx: '0, val: '0,
               src_idle: src_idle, snk_stall: snk_stall};
        pixel_plan.push_back(st);
    endtask

    // mostly accepted pixels with random levels, some noise and dark >= white
    task automatic plan_random_pixels(input int count);
        int white;
        int diff;
        int roll;
        bit eol;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            eol  = ($urandom_range(15) == 0);
            if (roll < 20 || plan_min_white >= GAIN_CEIL) begin
                plan_pixel($urandom_range(255), $urandom_range(255),
                           1'($urandom_range(1)));
            end else if (roll < 28) begin
                white = $urandom_range(255);
                plan_pixel(white, $urandom_range(255, white), eol);
            end else begin
                white = $urandom_range(255, plan_min_white + 1);
                // small differences reach the saturation region
                if (roll < 60) begin
                    diff = $urandom_range(1, (white < 32) ? white : 32);
                end else begin
                    diff = $urandom_range(1, white);
                end
                plan_pixel(white, white - diff, eol);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: plays the plan; a word stays on the bus until it is taken
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_plan
        logic       nxt_valid;
        logic       nxt_cfg;
        plan_step_t st;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            nxt_valid = s_valid && !s_ready;
            nxt_cfg   = cfg_valid && !cfg_ready;
            if (!nxt_valid && !nxt_cfg && pixel_plan.size() != 0) begin
                st = pixel_plan[0];
                case (st.kind)
                    STEP_PIXEL: begin
                        if ($urandom_range(99) >= src_idle_pct) begin
                            nxt_valid = 1'b1;
                            s_data <= st.px;
                            void'(pixel_plan.pop_front());
                        end
                    end
                    STEP_CFG: begin
                        nxt_cfg = 1'b1;
                        cfg_index <= st.idx;
                        cfg_data  <= st.val;
                        void'(pixel_plan.pop_front());
                    end
                    STEP_DRAIN: begin
                        // a word taken at this edge is not yet in the queue
                        if (!s_valid && pending_gains.size() == 0) begin
                            void'(pixel_plan.pop_front());
                        end
                    end
                    default: begin
                        src_idle_pct  = st.src_idle;
                        snk_stall_pct = st.snk_stall;
                        void'(pixel_plan.pop_front());
                    end
                endcase
            end
            s_valid   <= nxt_valid;
            cfg_valid <= nxt_cfg;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: register shadow, prediction on input, check on output, watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : watch_results
        out_word_t want;
        if (!aresetn) begin
            m_ready       <= 1'b0;
            cur_target    = LVL_W'(TARGET_AT_RESET);
            cur_min_white = LVL_W'(MIN_WHITE_AT_RST);
            quiet_cycles  = 0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TARGET_LEVEL:    cur_target    = cfg_data;
                    REG_MIN_WHITE_LEVEL: cur_min_white = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_gains.size() == 0) begin
                    note_mismatch("result word with nothing expected");
                end else begin
                    want = pending_gains.pop_front();
                    if (m_data.gain !== want.gain)
                        note_mismatch($sformatf("gain %0d, want %0d",
                                                m_data.gain, want.gain));
                    if (m_data.dark_out !== want.dark_out)
                        note_mismatch($sformatf("dark_out %0d, want %0d",
                                                m_data.dark_out, want.dark_out));
                    if (m_data.rejected !== want.rejected)
                        note_mismatch($sformatf("rejected %b, want %b",
                                                m_data.rejected, want.rejected));
                    if (m_data.saturated !== want.saturated)
                        note_mismatch($sformatf("saturated %b, want %b",
                                                m_data.saturated, want.saturated));
                    if (m_data.end_of_line_out !== want.end_of_line_out)
                        note_mismatch($sformatf("end_of_line_out %b, want %b",
                                                m_data.end_of_line_out,
                                                want.end_of_line_out));
                end
                result_count++;
            end
            if (s_valid && s_ready) begin
                pending_gains.push_back(shading_gain(s_data));
            end
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved in %0d cycles, %0d results pending",
                         WATCHDOG_LIMIT, pending_gains.size());
                $display("shading_gain_calc_core test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ------------------------------------------------------------------------
    initial begin : run_test
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        err_count     = 0;
        result_count  = 0;
        quiet_cycles  = 0;
        plan_min_white = MIN_WHITE_AT_RST;

        // directed, reset registers (target 240, min white 16)
        plan_pixel(0, 0, 1'b0);        // all-zero pixel: white too low
        plan_pixel(16, 0, 1'b1);       // white equal to min white
        plan_pixel(17, 0, 1'b0);       // just above min white, saturates
        plan_pixel(255, 254, 1'b1);    // difference of one, saturates
        plan_pixel(255, 255, 1'b0);    // white equal to dark
        plan_pixel(100, 101, 1'b0);    // white below dark
        plan_pixel(255, 0, 1'b1);      // quotient below one unit
        plan_pixel(250, 10, 1'b0);     // quotient exactly one unit
        plan_pixel(200, 100, 1'b0);    // mid-range gain
        plan_pixel(58, 10, 1'b0);      // quotient 320: just over the ceiling
        plan_pixel(59, 10, 1'b1);      // quotient 313: just under it
        plan_pixel(170, 85, 1'b0);     // alternating bit patterns
        // zero target: no gain anywhere
        plan_settings(0, MIN_WHITE_AT_RST);
        plan_pixel(255, 0, 1'b0);
        plan_pixel(17, 16, 1'b1);
        plan_pixel(10, 0, 1'b0);
        // extremes of both registers
        plan_settings(255, 0);
        plan_pixel(1, 0, 1'b0);
        plan_pixel(255, 0, 1'b1);
        plan_pixel(0, 0, 1'b0);
        plan_settings(255, 255);
        plan_pixel(255, 0, 1'b0);
        plan_pixel(254, 0, 1'b1);

        // random blocks, two register settings per idle phase but the last
        plan_phase(0, 0);
        plan_settings(TARGET_AT_RESET, MIN_WHITE_AT_RST);
        plan_random_pixels(BLOCK_PIXELS);
        plan_settings(255, 0);
        plan_random_pixels(BLOCK_PIXELS);
        plan_phase(62, 0);
        plan_settings(0, 0);
        plan_random_pixels(BLOCK_PIXELS);
        plan_settings($urandom_range(255), $urandom_range(64));
        plan_random_pixels(BLOCK_PIXELS);
        plan_phase(0, 62);
        plan_settings(1, 254);
        plan_random_pixels(BLOCK_PIXELS);
        plan_settings($urandom_range(255), $urandom_range(255));
        plan_random_pixels(BLOCK_PIXELS);
        plan_phase(32, 32);
        plan_settings(255, 255);
        plan_random_pixels(BLOCK_PIXELS / 4);
        plan_settings($urandom_range(128, 255), $urandom_range(32));
        plan_random_pixels(BLOCK_PIXELS);
        plan_phase(0, 0);
        plan_random_pixels(BLOCK_PIXELS / 2);
        plan_drain();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (pixel_plan.size() != 0 || s_valid || cfg_valid);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (err_count == 0 && pending_gains.size() == 0) begin
            $display("shading_gain_calc_core test passed");
        end else begin
            $display("shading_gain_calc_core test failed");
        end
        $finish;
    end

endmodule
